### design/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes, the classified item type and defaults.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 40;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MAX      = 4'd10,
        CMD_MIN      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } cmd_t;

    // Item after classification: simple results are already final here.
    typedef struct packed {
        cmd_t        op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic        cmp;
        logic        dz;
    } item_t;

endpackage

### design/fpa_front.sv
// Front end: accepts items, decodes the opcode and works out every operation but multiply and divide.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fpa_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          item_valid,
    input  logic                          item_ready,
    output fpa_pkg::item_t                item
);
    import fpa_pkg::*;

    logic        vld_reg;
    item_t       item_reg;
    item_t       item_next;
    logic signed [31:0] sa;
    logic signed [31:0] sb;

    assign sa = s_tdata[35:4];
    assign sb = s_tdata[67:36];

    always_comb
    begin
        item_next.op  = cmd_t'(s_tdata[3:0]);
        item_next.a   = sa;
        item_next.b   = sb;
        item_next.res = '0;
        item_next.cmp = 1'b0;
        item_next.dz  = 1'b0;
        case (item_next.op)
            CMD_ADD:      item_next.res = sa + sb;
            CMD_SUB:      item_next.res = sa - sb;
            CMD_DIV:      item_next.dz  = (sb == 32'sd0);
            CMD_GT:       item_next.cmp = (sa > sb);
            CMD_LT:       item_next.cmp = (sa < sb);
            CMD_GE:       item_next.cmp = (sa >= sb);
            CMD_LE:       item_next.cmp = (sa <= sb);
            CMD_EQ:       item_next.cmp = (sa == sb);
            CMD_NE:       item_next.cmp = (sa != sb);
            CMD_MAX:      item_next.res = (sa > sb) ? sa : sb;
            CMD_MIN:      item_next.res = (sa < sb) ? sa : sb;
            CMD_INC:      item_next.res = sa + 32'sd1;
            CMD_DEC:      item_next.res = sa - 32'sd1;
            CMD_FROM_INT: item_next.res = sa << FRAC_BITS;
            CMD_TO_INT:   item_next.res = sa >>> FRAC_BITS;
            default:      item_next.res = '0;   // mul finished in the back end
        endcase
    end

    assign s_tready   = !vld_reg || item_ready;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### design/fpa_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fpa_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fpa_pkg::item_t pop_item
);
    import fpa_pkg::*;

    item_t       mem_reg [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign pop_valid  = (count_reg != 2'd0);
    assign push_ready = (count_reg != 2'd2) || pop_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign do_push    = push_valid && push_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/fpa_back.sv
// Back end: multiplier and one-bit-per-stage pipelined divider, with the output register.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  fpa_pkg::item_t                 item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fpa_pkg::*;

    // dividend is |a| with FRAC_BITS zeros appended
    localparam int DW = 32 + FRAC_BITS;

    logic               adv;
    logic               vld_reg  [0:DW];
    item_t              info_reg [0:DW];
    logic [31:0]        rem_reg  [0:DW];
    logic [DW-1:0]      dvd_reg  [0:DW];
    logic [31:0]        dvs_reg  [0:DW];
    logic [31:0]        quo_reg  [0:DW];
    logic               neg_reg  [0:DW];
    logic signed [63:0] prod_reg;

    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [63:0] prod_next;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;

    logic               out_vld_reg;
    logic [31:0]        out_res_reg;
    logic               out_cmp_reg;
    logic               out_dz_reg;
    logic [31:0]        res_final;
    logic               last_is_div;

    // whole pipe moves together; only the output register can hold it back
    assign adv        = !out_vld_reg || m_tready;
    assign item_ready = adv;

    assign sa        = item.a;
    assign sb        = item.b;
    assign prod_next = sa * sb;
    assign mag_a     = item.a[31] ? (~item.a + 32'd1) : item.a;
    assign mag_b     = item.b[31] ? (~item.b + 32'd1) : item.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0] <= item;
            rem_reg[0]  <= '0;
            dvd_reg[0]  <= {mag_a, {FRAC_BITS{1'b0}}};
            dvs_reg[0]  <= mag_b;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= item.a[31] ^ item.b[31];
            prod_reg    <= prod_next;
        end
    end

    for (genvar k = 1; k <= DW; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;
        item_t       info_next;
        logic signed [63:0] prod_sh;

        assign trial   = {rem_reg[k-1], dvd_reg[k-1][DW-1]};
        assign ge      = (trial >= {1'b0, dvs_reg[k-1]});
        assign prod_sh = prod_reg >>> FRAC_BITS;

        always_comb
        begin
            info_next = info_reg[k-1];
            if ((k == 1) && (info_reg[k-1].op == CMD_MUL))
            begin
                info_next.res = prod_sh[31:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                info_reg[k] <= info_next;
                rem_reg[k]  <= ge ? 32'(trial - {1'b0, dvs_reg[k-1]}) : trial[31:0];
                dvd_reg[k]  <= dvd_reg[k-1] << 1;
                dvs_reg[k]  <= dvs_reg[k-1];
                quo_reg[k]  <= {quo_reg[k-1][30:0], ge};
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    assign last_is_div = (info_reg[DW].op == CMD_DIV) && !info_reg[DW].dz;
    assign res_final   = !last_is_div ? info_reg[DW].res
                       : (neg_reg[DW] ? (~quo_reg[DW] + 32'd1) : quo_reg[DW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= res_final;
            out_cmp_reg <= info_reg[DW].cmp;
            out_dz_reg  <= info_reg[DW].dz;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_dz_reg, out_cmp_reg, out_res_reg};

endmodule

### design/fixed_point_alu_unit.sv
// Fixed-point ALU unit: front end, item queue and back end pipeline.
// Path: front-end register, queue, back-end input register, divider stages and output register, for every opcode.
// Throughput: one item per cycle while m_tready does not stall the output; the divider is pipelined one bit per stage.
// Reset: rst_n asynchronous, active low; clears all valid flags, payload is not reset.
// Depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
`timescale 1ns / 1ps

module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  logic [fpa_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result[31:0], compare_true[32], divide_by_zero[33], zero pad
    output logic [fpa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fpa_pkg::*;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### design/fpa_checker.sv
// Port-level checks for the fixed-point ALU unit, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_unit.
`timescale 1ns / 1ps

module fpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fpa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fpa_pkg::*;

    // a stalled result must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("compare and divide-by-zero flags both set");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[31:0] == 32'd0))
        else $error("divide by zero with nonzero result");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
        else $error("comparison with nonzero result");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/fixed_point_alu_unit_test.sv
// Testbench for the fixed-point ALU unit: directed and random operations on the item stream.
// A scoreboard class predicts each result from the accepted input; depends on fpa_pkg and the RTL.
`timescale 1ns / 1ps

module fixed_point_alu_unit_test;
    import fpa_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 35;

    typedef struct {
        logic [31:0] res;
        logic        cmp;
        logic        dz;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;

        function alu_out_t compute(cmd_t op, logic [31:0] a, logic [31:0] b);
            alu_out_t    o;
            logic signed [63:0] sa, sb, prod, num;
            logic [63:0] ma, mb, q;
            logic        neg;
            sa = {{32{a[31]}}, a};
            sb = {{32{b[31]}}, b};
            o.res = '0;
            o.cmp = 1'b0;
            o.dz  = 1'b0;
            case (op)
                CMD_ADD:  o.res = a + b;
                CMD_SUB:  o.res = a - b;
                CMD_MUL:
                begin
                    prod  = sa * sb;
                    o.res = 32'(prod >>> FB);
                end
                CMD_DIV:
                begin
                    if (b == 32'd0)
                        o.dz = 1'b1;
                    else
                    begin
                        neg   = (sa < 0) != (sb < 0);
                        ma    = (sa < 0) ? -sa : sa;
                        mb    = (sb < 0) ? -sb : sb;
                        num   = ma << FB;
                        q     = num / mb;
                        o.res = 32'(neg ? -q : q);
                    end
                end
                CMD_GT:   o.cmp = sa > sb;
                CMD_LT:   o.cmp = sa < sb;
                CMD_GE:   o.cmp = sa >= sb;
                CMD_LE:   o.cmp = sa <= sb;
                CMD_EQ:   o.cmp = sa == sb;
                CMD_NE:   o.cmp = sa != sb;
                CMD_MAX:  o.res = (sa > sb) ? a : b;
                CMD_MIN:  o.res = (sa < sb) ? a : b;
                CMD_INC:  o.res = a + 32'd1;
                CMD_DEC:  o.res = a - 32'd1;
                CMD_FROM_INT: o.res = a << FB;
                default:  o.res = 32'(sa >>> FB);
            endcase
            return o;
        endfunction

        function void note_input(logic [IN_DATA_W-1:0] d);
            pending.push_back(compute(cmd_t'(d[3:0]), d[35:4], d[67:36]));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                $error("result item with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.res)
            begin
                $error("result: expected %h, actual %h", e.res, d[31:0]);
                errors++;
            end
            if (d[32] !== e.cmp)
            begin
                $error("compare_true: expected %b, actual %b", e.cmp, d[32]);
                errors++;
            end
            if (d[33] !== e.dz)
            begin
                $error("divide_by_zero: expected %b, actual %b", e.dz, d[33]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    alu_scoreboard sb;
    bit            no_idle;
    int            hold_cycles;

    fixed_point_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("fixed_point_alu_unit_test failed");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return 32'(int'($urandom_range(0, 2048)) - 1024);
            default: return $urandom();
        endcase
    endfunction

    // One item: offer it, idling now and then, and hold until accepted.
    task automatic send_op(cmd_t op, logic [31:0] a, logic [31:0] b);
        while (!no_idle && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a, op};
        do @(posedge clk); while (!s_tready);
        sb.note_input({4'b0, b, a, op});
    endtask

    // Receiver: random ready unless held off; always ready while no_idle is set.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready    <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
        end
    end

    initial
    begin
        logic [31:0] a, b;
        int          i;
        sb          = new();
        hold_cycles = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operation on extreme operands
        for (i = 0; i < 16; i++)
            send_op(cmd_t'(i), 32'h7fffffff, 32'h80000000);
        send_op(CMD_DIV, 32'h12345678, 32'd0);
        send_op(CMD_DIV, 32'h7fffffff, 32'd1);
        send_op(CMD_DIV, 32'hffffff00, 32'h00000300);
        send_op(CMD_MUL, 32'h80000000, 32'h80000000);
        send_op(CMD_TO_INT, 32'hffffff01, 32'd0);
        send_op(CMD_EQ, 32'h55555555, 32'h55555555);
        send_op(CMD_MAX, 32'h00000005, 32'h00000005);
        send_op(CMD_INC, 32'hffffffff, 32'hffffffff);
        send_op(CMD_DEC, 32'h80000000, 32'h0);

        for (i = 0; i < 450; i++)
        begin
            if (i == 100)
                hold_cycles <= 300;   // long back-pressure, source keeps offering
            if (i == 250)
            begin
                s_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            no_idle = (i >= 300 && i < 360);
            a = pick_word();
            b = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word();
            send_op(cmd_t'($urandom_range(0, 15)), a, b);
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0)
            $display("fixed_point_alu_unit_test passed");
        else
            $display("fixed_point_alu_unit_test failed");
        $finish;
    end
endmodule
